/* hw/rtl/srd_pkg.sv */
`default_nettype none

package srd_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_DATA_LENGTH  = 2'd2;

  localparam logic [15:0] IMAGE_WIDTH_RST  = 16'd640;
  localparam logic [15:0] IMAGE_HEIGHT_RST = 16'd480;
  localparam logic [15:0] DATA_LENGTH_RST  = 16'd0;

  // code bytes
  localparam logic [7:0] CODE_NEWLINE = 8'h00;
  localparam logic [7:0] CODE_END     = 8'h80;
  localparam logic [7:0] CODE_SKIP_LO = 8'h81;
  localparam logic [7:0] CODE_SKIP_HI = 8'hBF;
  localparam logic [7:0] CODE_C0      = 8'hC0;
  localparam logic [7:0] CODE_C1      = 8'hC1;
  localparam logic [7:0] CODE_LIT_LO  = 8'h01;
  localparam logic [7:0] CODE_LIT_HI  = 8'h7F;

  typedef enum logic [2:0] {
    CLS_NEWLINE,
    CLS_END,
    CLS_LITERAL,
    CLS_SKIP,
    CLS_C0,
    CLS_C1,
    CLS_FILL
  } code_class_e;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        new_sprite;
    code_class_e cls;
  } srd_item_t;

  typedef struct packed {
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [15:0] data_length;
  } srd_cfg_t;

endpackage

`default_nettype wire

/* hw/rtl/srd_front.sv */
`default_nettype none

module srd_front (
  input  logic              [7:0] data_byte_i,
  input  logic                    new_sprite_i,
  output srd_pkg::srd_item_t      item_o
);
  import srd_pkg::*;

  code_class_e cls;

  always_comb begin
    unique case (data_byte_i) inside
      CODE_NEWLINE:                 cls = CLS_NEWLINE;
      [CODE_LIT_LO:CODE_LIT_HI]:    cls = CLS_LITERAL;
      CODE_END:                     cls = CLS_END;
      [CODE_SKIP_LO:CODE_SKIP_HI]:  cls = CLS_SKIP;
      CODE_C0:                      cls = CLS_C0;
      CODE_C1:                      cls = CLS_C1;
      default:                      cls = CLS_FILL;
    endcase
  end

  assign item_o.data_byte  = data_byte_i;
  assign item_o.new_sprite = new_sprite_i;
  assign item_o.cls        = cls;

endmodule

`default_nettype wire

/* hw/rtl/srd_queue.sv */
`default_nettype none

module srd_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  srd_pkg::srd_item_t  push_item_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output srd_pkg::srd_item_t  pop_item_o
);
  import srd_pkg::*;

  srd_item_t  mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign full_o     = count_q[1];
  assign valid_o    = (count_q != 2'd0);
  assign pop_item_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    count_d  = count_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/srd_back.sv */
`default_nettype none

module srd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  srd_pkg::srd_cfg_t   cfg_i,
  input  logic                item_valid_i,
  input  srd_pkg::srd_item_t  item_i,
  output logic                item_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic         [15:0] run_x_o,
  output logic         [15:0] run_y_o,
  output logic          [7:0] run_length_o,
  output logic          [7:0] pixel_colour_o,
  output logic                sprite_done_o,
  output logic                overrun_o
);
  import srd_pkg::*;

  localparam logic [3:0] PH_OPCODE      = 4'd0;
  localparam logic [3:0] PH_HOLD        = 4'd1;
  localparam logic [3:0] PH_LITERAL     = 4'd2;
  localparam logic [3:0] PH_C0_ARG      = 4'd3;
  localparam logic [3:0] PH_C0_EXT      = 4'd4;
  localparam logic [3:0] PH_C1_COUNT    = 4'd5;
  localparam logic [3:0] PH_C1_COLOUR   = 4'd6;
  localparam logic [3:0] PH_FILL_COLOUR = 4'd7;
  localparam logic [3:0] PH_DONE        = 4'd8;

  logic [3:0]  phase_q, phase_d;
  logic [7:0]  held_q, held_d;
  code_class_e held_cls_q, held_cls_d;
  logic [15:0] col_q, col_d;
  logic [15:0] row_q, row_d;
  logic [15:0] bpos_q, bpos_d;
  logic [7:0]  pl_q, pl_d;

  logic        out_valid_q, out_valid_d;
  logic [15:0] ox_q, ox_d, oy_q, oy_d;
  logic [7:0]  olen_q, olen_d, ocol_q, ocol_d;
  logic        odone_q, odone_d, oovr_q, oovr_d;

  logic        slot_free;
  logic        take;

  function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  assign slot_free  = !out_valid_q || !out_stall_i;
  assign take       = item_valid_i && slot_free;
  assign item_pop_o = take;

  always_comb begin
    logic [7:0]  b;
    logic        hold_drop;
    logic        emit;
    logic [15:0] ex, ey;
    logic [7:0]  elen, ecolour;
    logic        edone, eovr;
    logic        do_run;
    logic [7:0]  run_cnt, run_colour;
    logic [15:0] room;

    b          = item_i.data_byte;
    phase_d    = phase_q;
    held_d     = held_q;
    held_cls_d = held_cls_q;
    col_d      = col_q;
    row_d      = row_q;
    bpos_d     = bpos_q;
    pl_d       = pl_q;
    emit       = 1'b0;
    ex         = col_q;
    ey         = row_q;
    elen       = 8'd0;
    ecolour    = 8'd0;
    edone      = 1'b0;
    eovr       = 1'b0;
    do_run     = 1'b0;
    run_cnt    = 8'd0;
    run_colour = 8'd0;
    room       = 16'd0;
    hold_drop  = 1'b0;

    if (item_i.new_sprite) begin
      col_d      = 16'd0;
      row_d      = 16'd0;
      bpos_d     = 16'd0;
      pl_d       = 8'd0;
      held_d     = 8'd0;
      held_cls_d = CLS_NEWLINE;
      phase_d    = PH_OPCODE;
    end

    if (phase_d == PH_DONE) begin
      // ended sprite, byte dropped
    end else if (bpos_d >= cfg_i.data_length) begin
      emit    = 1'b1;
      ex      = col_d;
      ey      = row_d;
      edone   = 1'b1;
      eovr    = 1'b1;
      phase_d = PH_DONE;
    end else begin
      bpos_d = bpos_d + 16'd1;

      // resolve a held code against this byte
      if (phase_d == PH_HOLD) begin
        hold_drop = (b == CODE_NEWLINE) ||
                    ((b == CODE_END) && (bpos_d == cfg_i.data_length));
        if (hold_drop) begin
          phase_d = PH_OPCODE;
        end else begin
          case (held_cls_q)
            CLS_LITERAL: begin
              pl_d    = held_q;
              phase_d = PH_LITERAL;
            end
            CLS_SKIP: begin
              col_d   = sat_add(col_d, {8'd0, held_q - CODE_END});
              phase_d = PH_OPCODE;
            end
            CLS_C0:   phase_d = PH_C0_ARG;
            CLS_C1:   phase_d = PH_C1_COUNT;
            CLS_FILL: begin
              pl_d    = held_q - CODE_C0;
              phase_d = PH_FILL_COLOUR;
            end
            default:  phase_d = PH_OPCODE;
          endcase
        end
      end

      if (phase_d == PH_OPCODE) begin
        // opcode dispatch
        if (item_i.cls == CLS_NEWLINE) begin
          row_d = sat_add(row_d, 16'd1);
          col_d = 16'd0;
        end else if (item_i.cls == CLS_END) begin
          emit    = 1'b1;
          ex      = col_d;
          ey      = row_d;
          edone   = 1'b1;
          phase_d = PH_DONE;
        end else if ({8'd0, b} <= cfg_i.image_width) begin
          held_d     = b;
          held_cls_d = item_i.cls;
          phase_d    = PH_HOLD;
        end else begin
          case (item_i.cls)
            CLS_LITERAL: begin
              pl_d    = b;
              phase_d = PH_LITERAL;
            end
            CLS_SKIP: col_d   = sat_add(col_d, {8'd0, b - CODE_END});
            CLS_C0:   phase_d = PH_C0_ARG;
            CLS_C1:   phase_d = PH_C1_COUNT;
            CLS_FILL: begin
              pl_d    = b - CODE_C0;
              phase_d = PH_FILL_COLOUR;
            end
            default:  phase_d = PH_OPCODE;
          endcase
        end
      end else begin
        // operand byte
        unique case (phase_d)
          PH_LITERAL: begin
            do_run     = 1'b1;
            run_cnt    = 8'd1;
            run_colour = b;
            if (pl_d != 8'd0) begin
              pl_d = pl_d - 8'd1;
            end
            if (pl_d == 8'd0) begin
              phase_d = PH_OPCODE;
            end
          end
          PH_C0_ARG: begin
            if (b[1:0] == 2'd0) begin
              phase_d = PH_C0_EXT;
            end else begin
              col_d   = sat_add(col_d, {14'd0, b[1:0]});
              phase_d = PH_OPCODE;
            end
          end
          PH_C0_EXT: begin
            col_d   = sat_add(col_d, {8'd0, b});
            phase_d = PH_OPCODE;
          end
          PH_C1_COUNT: begin
            pl_d    = b;
            phase_d = PH_C1_COLOUR;
          end
          PH_C1_COLOUR, PH_FILL_COLOUR: begin
            do_run     = 1'b1;
            run_cnt    = pl_d;
            run_colour = b;
            pl_d       = 8'd0;
            phase_d    = PH_OPCODE;
          end
          default: phase_d = PH_OPCODE;
        endcase
      end

      // clipped run, column moves by the full count
      if (do_run) begin
        room = cfg_i.image_width - col_d;
        if ((run_cnt != 8'd0) && (row_d < cfg_i.image_height) &&
            (col_d < cfg_i.image_width)) begin
          emit    = 1'b1;
          ex      = col_d;
          ey      = row_d;
          elen    = (room < {8'd0, run_cnt}) ? room[7:0] : run_cnt;
          ecolour = run_colour;
        end
        col_d = sat_add(col_d, {8'd0, run_cnt});
      end
    end

    out_valid_d = out_valid_q;
    ox_d        = ox_q;
    oy_d        = oy_q;
    olen_d      = olen_q;
    ocol_d      = ocol_q;
    odone_d     = odone_q;
    oovr_d      = oovr_q;
    if (slot_free) begin
      out_valid_d = take && emit;
      ox_d        = ex;
      oy_d        = ey;
      olen_d      = elen;
      ocol_d      = ecolour;
      odone_d     = edone;
      oovr_d      = eovr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_OPCODE;
      held_q      <= 8'd0;
      held_cls_q  <= CLS_NEWLINE;
      col_q       <= 16'd0;
      row_q       <= 16'd0;
      bpos_q      <= 16'd0;
      pl_q        <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        phase_q    <= phase_d;
        held_q     <= held_d;
        held_cls_q <= held_cls_d;
        col_q      <= col_d;
        row_q      <= row_d;
        bpos_q     <= bpos_d;
        pl_q       <= pl_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ox_q    <= ox_d;
    oy_q    <= oy_d;
    olen_q  <= olen_d;
    ocol_q  <= ocol_d;
    odone_q <= odone_d;
    oovr_q  <= oovr_d;
  end

  assign out_valid_o    = out_valid_q;
  assign run_x_o        = ox_q;
  assign run_y_o        = oy_q;
  assign run_length_o   = olen_q;
  assign pixel_colour_o = ocol_q;
  assign sprite_done_o  = odone_q;
  assign overrun_o      = oovr_q;

endmodule

`default_nettype wire

/* hw/rtl/sprite_rle_run_decoder.sv */
// Run-length sprite decoder: takes one coded byte per beat and gives at most
// one pixel run beat (x, y, length, colour) for it, clipped to the configured
// surface, plus an end beat with sprite_done set (and overrun set when the
// bytes ran past data_length). A byte with new_sprite set restarts position,
// row and byte count before it is decoded. Throughput is one byte per clock
// while the output is not stalled: the back end updates the whole decode state
// for each byte it takes, and a two-entry queue sits between the byte
// classifier and that back end, so a stall on the result side only backs up
// into the input once the queue is full. A result passes through a queue
// entry and then the output register. Configuration must be written only
// while the block is idle; the block itself does not enforce this.
`default_nettype none

module sprite_rle_run_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,

  // configuration write port
  input  logic        cfg_we_i,
  input  logic  [1:0] cfg_index_i,
  input  logic [15:0] cfg_wdata_i,

  // coded byte beats
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic  [7:0] data_byte_i,
  input  logic        new_sprite_i,

  // run beats
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] run_x_o,
  output logic [15:0] run_y_o,
  output logic  [7:0] run_length_o,
  output logic  [7:0] pixel_colour_o,
  output logic        sprite_done_o,
  output logic        overrun_o
);
  import srd_pkg::*;

  srd_cfg_t  cfg_q;
  srd_item_t front_item;
  srd_item_t queue_item;
  logic      queue_full;
  logic      queue_valid;
  logic      queue_pop;

  // configuration registers, out-of-range indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width  <= IMAGE_WIDTH_RST;
      cfg_q.image_height <= IMAGE_HEIGHT_RST;
      cfg_q.data_length  <= DATA_LENGTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg_wdata_i;
        CFG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_wdata_i;
        CFG_DATA_LENGTH:  cfg_q.data_length  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // front end: classify the code byte on the way in
  srd_front u_front (
    .data_byte_i  (data_byte_i),
    .new_sprite_i (new_sprite_i),
    .item_o       (front_item)
  );

  // decoupling queue, stall only when both entries are taken
  srd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_item_i (front_item),
    .full_o      (queue_full),
    .pop_i       (queue_pop),
    .valid_o     (queue_valid),
    .pop_item_o  (queue_item)
  );

  assign in_stall_o = queue_full;

  // back end: decode state, clipping and the output register
  srd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .item_valid_i   (queue_valid),
    .item_i         (queue_item),
    .item_pop_o     (queue_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .run_x_o        (run_x_o),
    .run_y_o        (run_y_o),
    .run_length_o   (run_length_o),
    .pixel_colour_o (pixel_colour_o),
    .sprite_done_o  (sprite_done_o),
    .overrun_o      (overrun_o)
  );

endmodule

`default_nettype wire

/* verif/run_beat_checker.sv */
module run_beat_checker
  import srd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_we_i,
  input  logic  [1:0] cfg_index_i,
  input  logic [15:0] cfg_wdata_i,

  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic  [7:0] data_byte_i,
  input  logic        new_sprite_i,

  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [15:0] run_x_i,
  input  logic [15:0] run_y_i,
  input  logic  [7:0] run_length_i,
  input  logic  [7:0] pixel_colour_i,
  input  logic        sprite_done_i,
  input  logic        overrun_i,

  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] SKIP_MOD_MASK = 8'h03;

  typedef enum logic [3:0] {
    ST_OPCODE,
    ST_HOLD,
    ST_LITERAL,
    ST_SKIP_ARG,
    ST_SKIP_EXT,
    ST_COUNT,
    ST_COUNT_COLOUR,
    ST_FILL_COLOUR,
    ST_ENDED
  } decode_state_e;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  len;
    logic [7:0]  colour;
    logic        done;
    logic        ovr;
  } pixel_run_t;

  pixel_run_t    pending_runs[$];
  pixel_run_t    got_run;
  pixel_run_t    exp_run;
  int            mismatches;

  logic [15:0]   width_r;
  logic [15:0]   height_r;
  logic [15:0]   length_r;
  decode_state_e state_r;
  logic [7:0]    held_code_r;
  logic [7:0]    pixels_left_r;
  logic [15:0]   col_r;
  logic [15:0]   row_r;
  logic [15:0]   byte_pos_r;

  function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  task automatic put_run(input logic [7:0] len, input logic [7:0] colour,
                         input logic done, input logic ovr);
    pending_runs.push_back({col_r, row_r, len, colour, done, ovr});
  endtask

  // clipped run at the current position, column moves by the full count
  task automatic paint(input logic [7:0] count, input logic [7:0] colour);
    logic [15:0] room;
    logic [7:0]  len;
    if (count != 8'd0 && row_r < height_r && col_r < width_r) begin
      room = width_r - col_r;
      if ({8'd0, count} < room) len = count;
      else len = room[7:0];
      put_run(len, colour, 1'b0, 1'b0);
    end
    col_r = sat_add16(col_r, {8'd0, count});
  endtask

  task automatic begin_code(input logic [7:0] b);
    logic [7:0] amt;
    if (b >= CODE_LIT_LO && b <= CODE_LIT_HI) begin
      pixels_left_r = b;
      state_r = ST_LITERAL;
    end else if (b >= CODE_SKIP_LO && b <= CODE_SKIP_HI) begin
      amt = b - CODE_END;
      col_r = sat_add16(col_r, {8'd0, amt});
      state_r = ST_OPCODE;
    end else if (b == CODE_C0) begin
      state_r = ST_SKIP_ARG;
    end else if (b == CODE_C1) begin
      state_r = ST_COUNT;
    end else if (b > CODE_C1) begin
      pixels_left_r = b - CODE_C0;
      state_r = ST_FILL_COLOUR;
    end else begin
      state_r = ST_OPCODE;
    end
  endtask

  task automatic take_code(input logic [7:0] b);
    if (b == CODE_NEWLINE) begin
      row_r = sat_add16(row_r, 16'd1);
      col_r = '0;
      state_r = ST_OPCODE;
    end else if (b == CODE_END) begin
      put_run(8'd0, 8'd0, 1'b1, 1'b0);
      state_r = ST_ENDED;
    end else if (width_r >= {8'd0, b}) begin
      // one-byte lookahead before the code runs
      held_code_r = b;
      state_r = ST_HOLD;
    end else begin
      begin_code(b);
    end
  endtask

  task automatic take_operand(input logic [7:0] n);
    case (state_r)
      ST_LITERAL: begin
        paint(8'd1, n);
        if (pixels_left_r != 8'd0) pixels_left_r = pixels_left_r - 8'd1;
        if (pixels_left_r == 8'd0) state_r = ST_OPCODE;
      end
      ST_SKIP_ARG: begin
        if ((n & SKIP_MOD_MASK) == 8'd0) begin
          state_r = ST_SKIP_EXT;
        end else begin
          col_r = sat_add16(col_r, {8'd0, n & SKIP_MOD_MASK});
          state_r = ST_OPCODE;
        end
      end
      ST_SKIP_EXT: begin
        col_r = sat_add16(col_r, {8'd0, n});
        state_r = ST_OPCODE;
      end
      ST_COUNT: begin
        pixels_left_r = n;
        state_r = ST_COUNT_COLOUR;
      end
      ST_COUNT_COLOUR, ST_FILL_COLOUR: begin
        paint(pixels_left_r, n);
        pixels_left_r = '0;
        state_r = ST_OPCODE;
      end
      default: state_r = ST_OPCODE;
    endcase
  endtask

  task automatic decode_beat(input logic [7:0] b, input logic ns);
    logic [16:0] next_pos;
    if (ns) begin
      col_r = '0;
      row_r = '0;
      byte_pos_r = '0;
      pixels_left_r = '0;
      held_code_r = '0;
      state_r = ST_OPCODE;
    end
    if (state_r != ST_ENDED) begin
      if (byte_pos_r >= length_r) begin
        put_run(8'd0, 8'd0, 1'b1, 1'b1);
        state_r = ST_ENDED;
      end else begin
        next_pos = {1'b0, byte_pos_r} + 17'd1;
        byte_pos_r = next_pos[15:0];
        if (state_r == ST_OPCODE) begin
          take_code(b);
        end else if (state_r == ST_HOLD) begin
          // held code is dropped on a newline or on an end code in the last byte
          if (b == CODE_NEWLINE || (b == CODE_END && next_pos >= {1'b0, length_r})) begin
            take_code(b);
          end else begin
            begin_code(held_code_r);
            if (state_r == ST_OPCODE) take_code(b);
            else take_operand(b);
          end
        end else begin
          take_operand(b);
        end
      end
    end
  endtask

  task automatic report_run(input bit have_exp, input pixel_run_t e, input pixel_run_t g);
    mismatches++;
    if (mismatches <= 10) begin
      if (have_exp)
        $display("%0t run mismatch: expected x=%0d y=%0d len=%0d colour=%0d done=%0b ovr=%0b",
                 $realtime, e.x, e.y, e.len, e.colour, e.done, e.ovr);
      else
        $display("%0t run beat with nothing expected", $realtime);
      $display("%0t   actual x=%0d y=%0d len=%0d colour=%0d done=%0b ovr=%0b",
               $realtime, g.x, g.y, g.len, g.colour, g.done, g.ovr);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_r = IMAGE_WIDTH_RST;
      height_r = IMAGE_HEIGHT_RST;
      length_r = DATA_LENGTH_RST;
      state_r = ST_OPCODE;
      held_code_r = '0;
      pixels_left_r = '0;
      col_r = '0;
      row_r = '0;
      byte_pos_r = '0;
      pending_runs.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_IMAGE_WIDTH:  width_r = cfg_wdata_i;
          CFG_IMAGE_HEIGHT: height_r = cfg_wdata_i;
          CFG_DATA_LENGTH:  length_r = cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        got_run = {run_x_i, run_y_i, run_length_i, pixel_colour_i, sprite_done_i, overrun_i};
        if (pending_runs.size() == 0) begin
          report_run(1'b0, '0, got_run);
        end else begin
          exp_run = pending_runs.pop_front();
          if (exp_run !== got_run) report_run(1'b1, exp_run, got_run);
        end
      end
      if (in_valid_i && !in_stall_i) decode_beat(data_byte_i, new_sprite_i);
      fail_count_o <= mismatches;
      pending_o <= pending_runs.size();
    end
  end

endmodule

/* verif/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import srd_pkg::*;

  // top opcode of the fill range
  localparam logic [7:0] CODE_FILL_HI = 8'hFF;
  // receiver hold-off length for the back-pressure check, in cycles
  localparam int LONG_HOLD = 160;
  // random part stops once about this many coded bytes went in
  localparam int ITEM_GOAL = 1800;

  typedef struct packed {
    logic       ns;
    logic [7:0] b;
  } coded_beat_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic  [1:0] cfg_index;
  logic [15:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic  [7:0] data_byte;
  logic        new_sprite;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] run_x;
  logic [15:0] run_y;
  logic  [7:0] run_length;
  logic  [7:0] pixel_colour;
  logic        sprite_done;
  logic        overrun;
  int          fail_count;
  int          pending;

  coded_beat_t byte_stream[$];
  int          items_sent;
  int          burst_left;
  bit          hold_req;

  sprite_rle_run_decoder uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .data_byte_i    (data_byte),
    .new_sprite_i   (new_sprite),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .run_x_o        (run_x),
    .run_y_o        (run_y),
    .run_length_o   (run_length),
    .pixel_colour_o (pixel_colour),
    .sprite_done_o  (sprite_done),
    .overrun_o      (overrun)
  );

  // the checker watches both channels and the config port on its own
  run_beat_checker checker_i (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .data_byte_i    (data_byte),
    .new_sprite_i   (new_sprite),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .run_x_i        (run_x),
    .run_y_i        (run_y),
    .run_length_i   (run_length),
    .pixel_colour_i (pixel_colour),
    .sprite_done_i  (sprite_done),
    .overrun_i      (overrun),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // 8 ns clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // hard stop in case the block hangs
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  // --- stimulus helpers ---

  task automatic queue_byte(input logic [7:0] b);
    byte_stream.push_back({1'b0, b});
  endtask

  // one beat: maybe open a new burst with a gap, then hold the beat until taken
  task automatic send_beat(input logic [7:0] b, input logic ns);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_valid <= 1'b1;
    data_byte <= b;
    new_sprite <= ns;
    do @(posedge clk); while (in_stall);
    burst_left--;
  endtask

  task automatic send_stream();
    coded_beat_t beat;
    while (byte_stream.size() != 0) begin
      beat = byte_stream.pop_front();
      send_beat(beat.b, beat.ns);
    end
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // all runs out, then a wait for bytes that leave no run behind
  task automatic wait_idle();
    @(negedge clk);
    wait (pending == 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(input logic [15:0] w, input logic [15:0] h, input logic [15:0] d);
    wait_idle();
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    write_reg(CFG_DATA_LENGTH, d);
  endtask

  // one well-formed code with random content, now and then a broken one
  task automatic add_op();
    logic [7:0] cnt;
    logic [7:0] arg;
    logic [7:0] code;
    case ($urandom_range(0, 11))
      0: queue_byte(CODE_NEWLINE);
      1, 2: begin
        // literal pixels, long counts kept rare
        cnt = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(CODE_LIT_LO, CODE_LIT_HI))
                                          : 8'($urandom_range(1, 6));
        queue_byte(cnt);
        repeat (cnt) queue_byte(8'($urandom_range(0, 255)));
      end
      3: queue_byte(8'($urandom_range(CODE_SKIP_LO, CODE_SKIP_HI)));
      4: begin
        // skip with argument, low bits clear at least half the time to reach the extended form
        arg = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 1) == 0) arg[1:0] = 2'b00;
        queue_byte(CODE_C0);
        queue_byte(arg);
        if (arg[1:0] == 2'b00) queue_byte(8'($urandom_range(0, 255)));
      end
      5: begin
        queue_byte(CODE_C1);
        queue_byte(8'($urandom_range(0, 255)));
        queue_byte(8'($urandom_range(0, 255)));
      end
      6, 7: begin
        queue_byte(8'($urandom_range(CODE_C1 + 1, CODE_FILL_HI)));
        queue_byte(8'($urandom_range(0, 255)));
      end
      8: queue_byte(8'($urandom_range(0, 255)));
      9: begin
        // held code cut short by a new line
        code = 8'($urandom_range(1, 255));
        if (code == CODE_END) code = CODE_C0;
        queue_byte(code);
        queue_byte(CODE_NEWLINE);
      end
      default: begin
        // end code used as a fill colour
        queue_byte(8'($urandom_range(CODE_C1 + 1, CODE_FILL_HI)));
        queue_byte(CODE_END);
      end
    endcase
  endtask

  task automatic add_sprite(input int target);
    int start;
    start = byte_stream.size();
    if ($urandom_range(0, 9) == 0) begin
      repeat (target) queue_byte(8'($urandom_range(0, 255)));
    end else begin
      while (byte_stream.size() - start < target) add_op();
    end
    items_sent += byte_stream.size() - start;
    byte_stream[start].ns = 1'b1;
    case ($urandom_range(0, 9))
      0: ;  // no end code, runs into the next sprite or an overrun
      1: begin
        queue_byte(8'($urandom_range(0, 255)));
        queue_byte(CODE_END);
      end
      default: queue_byte(CODE_END);
    endcase
    // trailing bytes after the end are ignored by the block
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) queue_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic pick_config(output logic [15:0] w, output logic [15:0] h,
                             output logic [15:0] d);
    case ($urandom_range(0, 7))
      0: w = 16'd1;
      1: w = 16'hFFFF;
      2: w = 16'd640;
      3, 4: w = 16'($urandom_range(2, 40));
      5: w = 16'($urandom_range(100, 300));
      6: w = 16'($urandom_range(41, 2000));
      default: w = 16'($urandom_range(1, 65535));
    endcase
    case ($urandom_range(0, 5))
      0: h = 16'd1;
      1: h = 16'hFFFF;
      2: h = 16'($urandom_range(1, 6));
      default: h = 16'($urandom_range(7, 600));
    endcase
    case ($urandom_range(0, 9))
      0: d = 16'd0;
      1: d = 16'd1;
      2: d = 16'hFFFF;
      default: d = 16'($urandom_range(4, 80));
    endcase
  endtask

  // --- receiver: stall patterns, plus long hold-offs on request ---
  initial begin
    int span;
    int pick;
    int k;
    out_stall = 1'b0;
    wait (rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        // block keeps taking bytes until its queue fills, then stalls the sender
        for (k = 0; k < LONG_HOLD; k++) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
      end
      pick = $urandom_range(0, 3);
      span = $urandom_range(8, 120);
      for (k = 0; k < span && !hold_req; k++) begin
        @(negedge clk);
        case (pick)
          0: out_stall <= 1'b0;                            // free running
          1: out_stall <= ($urandom_range(0, 3) == 0);     // light stalls
          2: out_stall <= ($urandom_range(0, 3) != 0);     // heavy stalls
          default: out_stall <= ((k % 6) < 2);             // periodic
        endcase
      end
    end
  end

  // --- main sequence ---
  initial begin
    logic [15:0] w;
    logic [15:0] h;
    logic [15:0] d;
    int phase_no;
    int target;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_IMAGE_WIDTH;
    cfg_wdata = '0;
    in_valid = 1'b0;
    data_byte = '0;
    new_sprite = 1'b0;
    items_sent = 0;
    burst_left = 0;
    hold_req = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset config has no data, so the first byte overruns; the next is ignored
    queue_byte(CODE_LIT_LO);
    byte_stream[0].ns = 1'b1;
    queue_byte(8'hAA);
    send_stream();

    // narrow, short surface: hold rule, clipping, both skip forms, counted fill
    configure(16'd4, 16'd2, 16'd20);
    queue_byte(CODE_LIT_LO + 8'd2);   // literal of three, held first
    byte_stream[0].ns = 1'b1;
    queue_byte(8'h11);
    queue_byte(8'h22);
    queue_byte(8'h33);
    queue_byte(CODE_C0 + 8'd3);       // fill of three, clipped to one
    queue_byte(8'hFF);
    queue_byte(CODE_NEWLINE);
    queue_byte(CODE_C0);              // argument with low bits clear, then extended skip
    queue_byte(8'h04);
    queue_byte(8'h02);
    queue_byte(CODE_C1);              // counted fill, clipped at the right edge
    queue_byte(8'hFF);
    queue_byte(8'h5A);
    queue_byte(CODE_NEWLINE);         // row now past the height
    queue_byte(CODE_LIT_LO);
    queue_byte(8'h77);
    queue_byte(CODE_SKIP_LO);
    queue_byte(CODE_FILL_HI);
    queue_byte(8'h00);
    queue_byte(CODE_END);
    queue_byte(8'h42);
    send_stream();

    // held code dropped by a new line, then by an end code in the last byte
    configure(16'd640, 16'd480, 16'd4);
    queue_byte(CODE_C0 + 8'd5);
    byte_stream[0].ns = 1'b1;
    queue_byte(CODE_NEWLINE);
    queue_byte(CODE_C0 + 8'd5);
    queue_byte(CODE_END);
    queue_byte(8'h10);
    send_stream();

    // random phases, the first three on extreme settings
    items_sent = 0;
    phase_no = 0;
    while (items_sent < ITEM_GOAL) begin
      case (phase_no)
        0: begin
          w = 16'd1;
          h = 16'd1;
          d = 16'd40;
        end
        1: begin
          w = 16'hFFFF;
          h = 16'hFFFF;
          d = 16'hFFFF;
        end
        2: begin
          pick_config(w, h, d);
          d = 16'd1;
        end
        default: pick_config(w, h, d);
      endcase
      configure(w, h, d);
      if (phase_no == 1 || $urandom_range(0, 7) == 0) hold_req = 1'b1;
      repeat ($urandom_range(2, 5)) begin
        if (d != 16'd0 && d < 16'd200 && $urandom_range(0, 1) == 0)
          target = (d > 16'd1) ? d - 1 : 1;
        else
          target = $urandom_range(1, 60);
        add_sprite(target);
      end
      send_stream();
      phase_no++;
    end

    wait_idle();
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
